// ===== src/scw_pkg.sv =====
package scw_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SIZE_W  = CNT_W + 1;
  localparam int unsigned NSTG    = 14;

  localparam logic [4:0] REC_LONG  = 5'd16;
  localparam logic [4:0] REC_SHORT = 5'd8;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_FIXED = 2'd1,
    MODE_FRAME = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_ABOVE  = 2'd1,
    CFG_BELOW  = 2'd2,
    CFG_BUDGET = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ARCH_X86_64  = 3'd0,
    ARCH_X86     = 3'd1,
    ARCH_AARCH64 = 3'd2,
    ARCH_ARM32   = 3'd3,
    ARCH_OTHER   = 3'd4
  } arch_t;

  // everything an item carries down the pipe; each stage fills in its part
  typedef struct packed {
    logic                active;
    logic                frame;
    logic                fp_ok;
    logic                missing;
    logic [4:0]          fp_sz;
    logic [ADDR_W-1:0]   sp;
    logic [ADDR_W-1:0]   fp;
    logic [ADDR_W-1:0]   fe;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   wend;
    logic [ADDR_W-1:0]   ovs;
    logic [ADDR_W-1:0]   ove;
    logic [CNT_W-1:0]    lo;
    logic [CNT_W-1:0]    hi;
    logic [CNT_W-1:0]    avail;
    logic [4:0]          ov;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   limit;
    logic [SIZE_W-1:0]   excess;
    logic                wpres;
    logic                p0;
    logic                p1;
    logic [ADDR_W-1:0]   b0;
    logic [ADDR_W-1:0]   e0;
    logic [ADDR_W-1:0]   b1;
    logic [ADDR_W-1:0]   e1;
    logic [ADDR_W-1:0]   sz0;
    logic [ADDR_W-1:0]   sz1;
  } pipe_t;

  // end address of a range, saturating at the top of the address space
  function automatic logic [ADDR_W-1:0] sat_end(input logic [ADDR_W-1:0] b,
                                                input logic [SIZE_W-1:0] s);
    logic [ADDR_W:0] sum;
    sum = {1'b0, b} + {{(ADDR_W-SIZE_W+1){1'b0}}, s};
    return sum[ADDR_W] ? {ADDR_W{1'b1}} : sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== src/stack_capture_window.sv =====
// Stack capture window. Each beat on the input carries one register snapshot
// (stack pointer, frame pointer, architecture code); each output beat carries
// up to two disjoint address ranges, sorted by base and merged when they
// touch, plus a flag for a missing frame record in frame mode. The block is a
// 14-stage pipeline with no state between items: it takes one beat per cycle
// unless every stage is full while the output is stalled, and a result is
// delayed only while the output is stalled. Configuration is written through
// cfg_we/cfg_index/cfg_wdata and must only change while no beat is in flight.
module stack_capture_window
  import scw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       in_stack_pointer,
  input  logic [63:0]       in_frame_pointer,
  input  logic [2:0]        in_arch_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_first_present,
  output logic [63:0]       out_first_base,
  output logic [63:0]       out_first_size,
  output logic              out_second_present,
  output logic [63:0]       out_second_base,
  output logic [63:0]       out_second_size,
  output logic              out_frame_missing
);

  logic [1:0]       mode_r;
  logic [CNT_W-1:0] above_r;
  logic [CNT_W-1:0] below_r;
  logic [CNT_W-1:0] budget_r;

  pipe_t            stg_r   [NSTG];
  pipe_t            stg_nxt [NSTG];
  logic [NSTG-1:0]  vld_r;
  logic [NSTG-1:0]  vld_nxt;
  logic [NSTG:0]    rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NONE;
      above_r  <= '0;
      below_r  <= '0;
      budget_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_wdata[1:0];
        CFG_ABOVE:  above_r  <= cfg_wdata;
        CFG_BELOW:  below_r  <= cfg_wdata;
        CFG_BUDGET: budget_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage can load when it is empty or its occupant moves on
  assign rdy[NSTG] = !out_stall;
  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_rdy
      assign rdy[g] = !vld_r[g] || rdy[g+1];
    end
  endgenerate

  assign in_stall = !rdy[0];

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_comb begin
    logic             raw_ok;
    logic [63:0]      ov_diff;
    logic [SIZE_W-1:0] room;
    logic [CNT_W-1:0] cut;

    // stage 0: window below the stack pointer, frame record checks
    stg_nxt[0]        = '0;
    stg_nxt[0].sp     = in_stack_pointer;
    stg_nxt[0].fp     = in_frame_pointer;
    stg_nxt[0].active = (mode_r != MODE_NONE) && (in_stack_pointer != '0);
    stg_nxt[0].frame  = (mode_r >= MODE_FRAME);
    stg_nxt[0].lo     = (in_stack_pointer < {32'd0, below_r}) ?
                        in_stack_pointer[CNT_W-1:0] : below_r;
    stg_nxt[0].hi     = above_r;
    unique case (in_arch_code)
      ARCH_X86_64, ARCH_X86:   raw_ok = in_frame_pointer > in_stack_pointer;
      ARCH_AARCH64, ARCH_ARM32: raw_ok = in_frame_pointer >= in_stack_pointer;
      default:                 raw_ok = 1'b0;
    endcase
    raw_ok = raw_ok && (in_frame_pointer != '0);
    stg_nxt[0].fp_ok   = stg_nxt[0].active && stg_nxt[0].frame && raw_ok;
    stg_nxt[0].missing = stg_nxt[0].active && stg_nxt[0].frame && !raw_ok;
    stg_nxt[0].fp_sz   = (in_arch_code == ARCH_X86_64 || in_arch_code == ARCH_AARCH64) ?
                         REC_LONG : REC_SHORT;

    // stage 1: window base and size, record end, budget left after the record
    stg_nxt[1]       = stg_r[0];
    stg_nxt[1].base  = stg_r[0].sp - {32'd0, stg_r[0].lo};
    stg_nxt[1].size  = {1'b0, stg_r[0].lo} + {1'b0, stg_r[0].hi};
    stg_nxt[1].fe    = sat_end(stg_r[0].fp, {28'd0, stg_r[0].fp_sz});
    stg_nxt[1].avail = (budget_r > {27'd0, stg_r[0].fp_sz}) ?
                       budget_r - {27'd0, stg_r[0].fp_sz} : '0;

    // stage 2: window end
    stg_nxt[2]      = stg_r[1];
    stg_nxt[2].wend = sat_end(stg_r[1].base, stg_r[1].size);

    // stage 3: bounds of the window/record intersection
    stg_nxt[3]     = stg_r[2];
    stg_nxt[3].ovs = (stg_r[2].base > stg_r[2].fp) ? stg_r[2].base : stg_r[2].fp;
    stg_nxt[3].ove = (stg_r[2].wend < stg_r[2].fe) ? stg_r[2].wend : stg_r[2].fe;

    // stage 4: overlap length, never more than the record
    stg_nxt[4]    = stg_r[3];
    ov_diff       = stg_r[3].ove - stg_r[3].ovs;
    stg_nxt[4].ov = (stg_r[3].ovs < stg_r[3].ove) ? ov_diff[4:0] : 5'd0;

    // stage 5: limit for the window
    stg_nxt[5] = stg_r[4];
    room       = {1'b0, stg_r[4].avail} + {28'd0, stg_r[4].ov};
    stg_nxt[5].limit = (stg_r[4].frame && stg_r[4].fp_ok && budget_r != '0 &&
                        stg_r[4].size > room) ? room : {1'b0, budget_r};

    // stage 6: bytes to trim, zero when a limit of zero means unlimited
    stg_nxt[6] = stg_r[5];
    stg_nxt[6].excess = (stg_r[5].size != '0 && stg_r[5].limit != '0 &&
                         stg_r[5].size > stg_r[5].limit) ?
                        stg_r[5].size - stg_r[5].limit : '0;

    // stage 7: trim above first
    stg_nxt[7]        = stg_r[6];
    cut               = (stg_r[6].excess < {1'b0, stg_r[6].hi}) ?
                        stg_r[6].excess[CNT_W-1:0] : stg_r[6].hi;
    stg_nxt[7].hi     = stg_r[6].hi - cut;
    stg_nxt[7].excess = stg_r[6].excess - {1'b0, cut};

    // stage 8: then below, moving the base up
    stg_nxt[8]      = stg_r[7];
    cut             = (stg_r[7].excess < {1'b0, stg_r[7].lo}) ?
                      stg_r[7].excess[CNT_W-1:0] : stg_r[7].lo;
    stg_nxt[8].lo   = stg_r[7].lo - cut;
    stg_nxt[8].base = stg_r[7].base + {32'd0, cut};

    // stage 9: trimmed size
    stg_nxt[9]      = stg_r[8];
    stg_nxt[9].size = {1'b0, stg_r[8].lo} + {1'b0, stg_r[8].hi};

    // stage 10: trimmed end
    stg_nxt[10]       = stg_r[9];
    stg_nxt[10].wend  = sat_end(stg_r[9].base, stg_r[9].size);
    stg_nxt[10].wpres = stg_r[9].active && (stg_r[9].size != '0);

    // stage 11: order the two candidate ranges
    stg_nxt[11]    = stg_r[10];
    stg_nxt[11].p0 = stg_r[10].wpres || stg_r[10].fp_ok;
    stg_nxt[11].p1 = stg_r[10].wpres && stg_r[10].fp_ok;
    if (stg_r[10].wpres && stg_r[10].fp_ok && stg_r[10].fp < stg_r[10].base) begin
      stg_nxt[11].b0 = stg_r[10].fp;
      stg_nxt[11].e0 = stg_r[10].fe;
      stg_nxt[11].b1 = stg_r[10].base;
      stg_nxt[11].e1 = stg_r[10].wend;
    end else if (stg_r[10].wpres) begin
      stg_nxt[11].b0 = stg_r[10].base;
      stg_nxt[11].e0 = stg_r[10].wend;
      stg_nxt[11].b1 = stg_r[10].fp;
      stg_nxt[11].e1 = stg_r[10].fe;
    end else begin
      stg_nxt[11].b0 = stg_r[10].fp;
      stg_nxt[11].e0 = stg_r[10].fe;
      stg_nxt[11].b1 = stg_r[10].base;
      stg_nxt[11].e1 = stg_r[10].wend;
    end

    // stage 12: merge when the ranges overlap or touch
    stg_nxt[12] = stg_r[11];
    if (stg_r[11].p1 && !(stg_r[11].b1 > stg_r[11].e0)) begin
      stg_nxt[12].p1 = 1'b0;
      stg_nxt[12].e0 = (stg_r[11].e1 > stg_r[11].e0) ? stg_r[11].e1 : stg_r[11].e0;
    end

    // stage 13: sizes, absent ranges read as zero
    stg_nxt[13]     = stg_r[12];
    stg_nxt[13].b0  = stg_r[12].p0 ? stg_r[12].b0 : '0;
    stg_nxt[13].sz0 = stg_r[12].p0 ? stg_r[12].e0 - stg_r[12].b0 : '0;
    stg_nxt[13].b1  = stg_r[12].p1 ? stg_r[12].b1 : '0;
    stg_nxt[13].sz1 = stg_r[12].p1 ? stg_r[12].e1 - stg_r[12].b1 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid          = vld_r[NSTG-1];
  assign out_first_present  = stg_r[NSTG-1].p0;
  assign out_first_base     = stg_r[NSTG-1].b0;
  assign out_first_size     = stg_r[NSTG-1].sz0;
  assign out_second_present = stg_r[NSTG-1].p1;
  assign out_second_base    = stg_r[NSTG-1].b1;
  assign out_second_size    = stg_r[NSTG-1].sz1;
  assign out_frame_missing  = stg_r[NSTG-1].missing;

`ifndef ASSERT_OFF
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_present |-> out_first_present)
    else $error("second range without first");

  a_ranges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_present |->
      out_second_base > (out_first_base + out_first_size))
    else $error("ranges not sorted or should have merged");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_first_present |->
      out_first_base == '0 && out_first_size == '0 && !out_second_present)
    else $error("absent range carries data");

  a_entry_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> !in_stall)
    else $error("input stalled with first stage empty");
`endif

endmodule

// ===== tb/sv/tb_stack_capture_window.sv =====
`timescale 1ns / 100ps

module tb_stack_capture_window;
  import scw_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 30;
  localparam int unsigned BLOCKS       = 8;
  localparam int unsigned BLOCK_ITEMS  = 42;

  // codes the package leaves unnamed
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [2:0] ARCH_SPARE = 3'd7;

  typedef struct {
    logic        first_present;
    logic [63:0] first_base;
    logic [63:0] first_size;
    logic        second_present;
    logic [63:0] second_base;
    logic [63:0] second_size;
    logic        frame_missing;
  } capture_t;

  typedef struct {
    logic [63:0] base;
    logic [63:0] size;
    logic [63:0] lo;
    logic [63:0] hi;
  } window_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] above;
    logic [31:0] below;
    logic [31:0] budget;
    logic [63:0] sp;
    logic [63:0] fp;
    logic [2:0]  arch;
    bit          known;
    capture_t    res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = CFG_MODE;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [63:0]       in_stack_pointer = '0;
  logic [63:0]       in_frame_pointer = '0;
  logic [2:0]        in_arch_code = ARCH_X86_64;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_first_present;
  logic [63:0]       out_first_base;
  logic [63:0]       out_first_size;
  logic              out_second_present;
  logic [63:0]       out_second_base;
  logic [63:0]       out_second_size;
  logic              out_frame_missing;

  // register copies seen by the predictor
  logic [1:0]  cur_mode = MODE_NONE;
  logic [31:0] cur_above = '0;
  logic [31:0] cur_below = '0;
  logic [31:0] cur_budget = '0;

  capture_t    pending_ranges[$];
  dir_row_t    dir_rows[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;
  int unsigned cycles = 0;

  stack_capture_window u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stack_pointer   (in_stack_pointer),
    .in_frame_pointer   (in_frame_pointer),
    .in_arch_code       (in_arch_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_first_present  (out_first_present),
    .out_first_base     (out_first_base),
    .out_first_size     (out_first_size),
    .out_second_present (out_second_present),
    .out_second_base    (out_second_base),
    .out_second_size    (out_second_size),
    .out_frame_missing  (out_frame_missing)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] range_end(input logic [63:0] b, input logic [63:0] s);
    logic [64:0] sum;
    sum = {1'b0, b} + {1'b0, s};
    return sum[64] ? {64{1'b1}} : sum[63:0];
  endfunction

  function automatic logic [63:0] min64(input logic [63:0] a, input logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  // take the excess off the above part first, then off the below part
  function automatic window_t trim_window(input window_t w, input logic [63:0] limit);
    window_t r;
    logic [63:0] excess;
    logic [63:0] cut;
    if (w.size == 0 || limit == 0 || w.size <= limit) return w;
    excess = w.size - limit;
    cut = min64(w.hi, excess);
    r.hi = w.hi - cut;
    excess -= cut;
    cut = min64(w.lo, excess);
    r.lo = w.lo - cut;
    r.base = w.base + (w.lo - r.lo);
    r.size = r.lo + r.hi;
    return r;
  endfunction

  function automatic capture_t predict_capture(input logic [63:0] sp, input logic [63:0] fp,
                                               input logic [2:0] arch);
    capture_t r;
    window_t w;
    logic [63:0] rb0, re0, rb1, re1, b0, e0, b1, e1;
    logic [63:0] rec, fe, we, ovs, ove, ov, avail, limit;
    int n;
    bit fp_ok;
    bit missing;
    r = '{default: '0};
    rb0 = '0; re0 = '0; rb1 = '0; re1 = '0;
    rec = '0;
    n = 0;
    fp_ok = 0;
    missing = 0;
    if (cur_mode != MODE_NONE && sp != 0) begin
      w.lo = (sp < {32'd0, cur_below}) ? sp : {32'd0, cur_below};
      w.hi = {32'd0, cur_above};
      w.base = sp - w.lo;
      w.size = w.lo + w.hi;
      if (cur_mode == MODE_FIXED) begin
        w = trim_window(w, {32'd0, cur_budget});
      end else begin
        if (fp != 0) begin
          case (arch)
            ARCH_X86_64, ARCH_X86:    fp_ok = (fp > sp);
            ARCH_AARCH64, ARCH_ARM32: fp_ok = (fp >= sp);
            default:                  fp_ok = 0;
          endcase
          rec = (arch == ARCH_X86_64 || arch == ARCH_AARCH64) ? 64'(REC_LONG) : 64'(REC_SHORT);
        end
        missing = !fp_ok;
        if (cur_budget != 0) begin
          limit = {32'd0, cur_budget};
          if (fp_ok) begin
            we = range_end(w.base, w.size);
            fe = range_end(fp, rec);
            ovs = (w.base > fp) ? w.base : fp;
            ove = min64(we, fe);
            ov = (ovs < ove) ? ove - ovs : 64'd0;
            avail = (limit > rec) ? limit - rec : 64'd0;
            if (w.size > avail + ov) limit = avail + ov;
          end
          w = trim_window(w, limit);
        end
      end
      if (w.size > 0) begin
        rb0 = w.base;
        re0 = range_end(w.base, w.size);
        n = 1;
      end
      if (fp_ok) begin
        fe = range_end(fp, rec);
        if (n == 0) begin
          rb0 = fp;
          re0 = fe;
          n = 1;
        end else begin
          b0 = rb0; e0 = re0; b1 = fp; e1 = fe;
          if (b1 < b0) begin
            b1 = rb0; e1 = re0; b0 = fp; e0 = fe;
          end
          if (b1 > e0) begin
            rb0 = b0; re0 = e0; rb1 = b1; re1 = e1;
            n = 2;
          end else begin
            rb0 = b0;
            re0 = (e0 > e1) ? e0 : e1;
            n = 1;
          end
        end
      end
    end
    if (n >= 1) begin
      r.first_present = 1'b1;
      r.first_base = rb0;
      r.first_size = re0 - rb0;
    end
    if (n == 2) begin
      r.second_present = 1'b1;
      r.second_base = rb1;
      r.second_size = re1 - rb1;
    end
    r.frame_missing = missing;
    return r;
  endfunction

  function automatic void add_snapshot(input logic [1:0] mode, input logic [31:0] above,
                                       input logic [31:0] below, input logic [31:0] budget,
                                       input logic [63:0] sp, input logic [63:0] fp,
                                       input logic [2:0] arch, input bit known = 0,
                                       input logic p0 = 0, input logic [63:0] b0 = 0,
                                       input logic [63:0] s0 = 0, input logic miss = 0);
    dir_row_t r;
    r.mode = mode; r.above = above; r.below = below; r.budget = budget;
    r.sp = sp; r.fp = fp; r.arch = arch; r.known = known;
    r.res = '{default: '0};
    r.res.first_present = p0;
    r.res.first_base = b0;
    r.res.first_size = s0;
    r.res.frame_missing = miss;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(64));
      3:       return 32'($urandom_range(4096));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_budget();
    case ($urandom_range(6))
      0, 1:    return 32'd0;
      2:       return 32'($urandom_range(1, 40));
      3:       return 32'($urandom_range(4096));
      4:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_MODE:   cur_mode = val[1:0];
      CFG_ABOVE:  cur_above = val;
      CFG_BELOW:  cur_below = val;
      CFG_BUDGET: cur_budget = val;
    endcase
  endtask

  // only written with the pipe empty
  task automatic apply_cfg(input logic [1:0] mode, input logic [31:0] above,
                           input logic [31:0] below, input logic [31:0] budget);
    logic [31:0] junk;
    junk = $urandom;
    in_valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    write_reg(CFG_MODE, {junk[31:2], mode});
    write_reg(CFG_ABOVE, above);
    write_reg(CFG_BELOW, below);
    write_reg(CFG_BUDGET, budget);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic send_snapshot(input logic [63:0] sp, input logic [63:0] fp,
                               input logic [2:0] arch, input bit known, input capture_t res);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_stack_pointer <= sp;
    in_frame_pointer <= fp;
    in_arch_code <= arch;
    do @(posedge clk); while (in_stall);
    pending_ranges.insert(pending_ranges.size(),
                          known ? res : predict_capture(sp, fp, arch));
    n_sent++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // result side: check every accepted beat, then pick the stall for the next cycle
  always @(posedge clk) begin
    capture_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_ranges.size() == 0) begin
        $error("result beat with no snapshot outstanding");
        errors++;
      end else begin
        want = pending_ranges.pop_front();
        check_field("first_present", 64'(want.first_present), 64'(out_first_present));
        check_field("first_base", want.first_base, out_first_base);
        check_field("first_size", want.first_size, out_first_size);
        check_field("second_present", 64'(want.second_present), 64'(out_second_present));
        check_field("second_base", want.second_base, out_second_base);
        check_field("second_size", want.second_size, out_second_size);
        check_field("frame_missing", 64'(want.frame_missing), 64'(out_frame_missing));
        n_checked++;
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $error("run exceeded %0d cycles", LIMIT_CYCLES);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    capture_t no_res;
    dir_row_t r;
    logic [63:0] sp, fp;
    logic [2:0] arch;
    logic [1:0] mode;
    int unsigned pick;

    no_res = '{default: '0};

    // reset state, then clipping and saturation in fixed mode
    add_snapshot(MODE_NONE, 0, 0, 0, '1, '1, ARCH_X86_64, 1);
    add_snapshot(MODE_FIXED, 32'h100, 32'h100, 0, 0, 0, ARCH_X86_64, 1);
    add_snapshot(MODE_FIXED, 32'h100, 32'h100, 0, 64'h1000, 0, ARCH_OTHER, 1,
                 1, 64'hF00, 64'h200);
    add_snapshot(MODE_FIXED, 32'h100, 32'h100, 0, 64'h80, 0, ARCH_X86_64, 1,
                 1, 64'h0, 64'h180);
    add_snapshot(MODE_FIXED, '1, '1, 0, 64'hFFFF_FFFF_FFFF_FFF0, 0, ARCH_X86_64, 1,
                 1, 64'hFFFF_FFFE_FFFF_FFF1, 64'h0000_0001_0000_000E);
    // budget trims above first, then below
    add_snapshot(MODE_FIXED, 32'h100, 32'h100, 32'h180, 64'h1000, 0, ARCH_X86_64);
    add_snapshot(MODE_FIXED, 32'h100, 32'h100, 32'h80, 64'h1000, 0, ARCH_X86_64);
    add_snapshot(MODE_FIXED, 32'h100, 32'h100, 32'h1, 64'h1000, 0, ARCH_X86_64);
    // frame mode: record validity per architecture, merging, touching
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 64'h1000, 0, ARCH_X86_64, 1,
                 1, 64'hFC0, 64'h80, 1);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 64'h1000, 64'h2000, ARCH_X86_64);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 64'h1000, 64'h1000, ARCH_X86_64);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 64'h1000, 64'h1000, ARCH_AARCH64);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 64'h1000, 64'h1040, ARCH_ARM32);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 64'h1000, 64'h800, ARCH_AARCH64);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 64'h1000, 64'h2000, ARCH_OTHER, 1,
                 1, 64'hFC0, 64'h80, 1);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 64'h1000, 64'h2000, ARCH_SPARE, 1,
                 1, 64'hFC0, 64'h80, 1);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 64'h1000, 64'hFFFF_FFFF_FFFF_FFF8,
                 ARCH_X86_64);
    // budget below the record size, and a budget with overlap credit
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 32'h8, 64'h1000, 64'h2000, ARCH_X86_64);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 32'h50, 64'h1000, 64'h1020, ARCH_AARCH64);
    add_snapshot(MODE_SPARE, 32'h40, 32'h40, 0, 64'h1000, 64'h2000, ARCH_X86);
    add_snapshot(MODE_FRAME, 0, 0, 0, 64'h1000, 64'h1000, ARCH_AARCH64, 1,
                 1, 64'h1000, 64'h10);
    add_snapshot(MODE_FRAME, '1, '1, '1, '1, '1, ARCH_ARM32);
    add_snapshot(MODE_FRAME, 32'h40, 32'h40, 0, 0, 64'h2000, ARCH_X86_64, 1);
    add_snapshot(MODE_NONE, 32'h40, 32'h40, 0, 64'h1000, 64'h2000, ARCH_X86_64, 1);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.mode != cur_mode || r.above != cur_above || r.below != cur_below ||
          r.budget != cur_budget)
        apply_cfg(r.mode, r.above, r.below, r.budget);
      send_snapshot(r.sp, r.fp, r.arch, r.known, r.res);
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 34; recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        pick = $urandom_range(9);
        if (pick == 0)      mode = MODE_NONE;
        else if (pick <= 3) mode = MODE_FIXED;
        else if (pick <= 8) mode = MODE_FRAME;
        else                mode = MODE_SPARE;
        apply_cfg(mode, pick_count(), pick_count(), pick_budget());
        // long receiver hold with the sender still pushing, so the pipe backs up
        if (ph == 2 && blk == 0) hold_req++;
        for (int k = 0; k < BLOCK_ITEMS; k++) begin
          case ($urandom_range(7))
            0:       sp = 64'($urandom_range(4096));
            1:       sp = {64{1'b1}} - 64'($urandom_range(4096));
            2:       sp = {32'd0, $urandom};
            default: sp = {$urandom, $urandom};
          endcase
          if ($urandom_range(39) == 0) sp = '0;
          case ($urandom_range(8))
            0:       fp = '0;
            1:       fp = sp;
            2:       fp = sp + 64'($urandom_range(1, 64));
            3:       fp = sp - 64'($urandom_range(1, 64));
            4:       fp = sp + {32'd0, cur_above} + 64'($urandom_range(32)) - 64'd16;
            5:       fp = sp - {32'd0, cur_below} + 64'($urandom_range(32)) - 64'd16;
            6:       fp = {64{1'b1}} - 64'($urandom_range(20));
            default: fp = {$urandom, $urandom};
          endcase
          arch = ($urandom_range(9) < 8) ? 3'($urandom_range(3)) : 3'($urandom_range(4, 7));
          send_snapshot(sp, fp, arch, 0, no_res);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d snapshots sent and %0d range results checked over %0d register settings,",
             n_sent, n_checked, n_settings);
    $display("with input and output stalls mixed in and one long output hold");
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/scw_pkg.sv
src/stack_capture_window.sv
tb/sv/tb_stack_capture_window.sv
